>>> hdl/omap_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the outlier moving-average ping-pong block
// no dependencies
package omap_pkg;

    localparam int WINDOW_LEN = 10;
    localparam int BANK_DEPTH = 1024;

    localparam int SAMPLE_W = 12;
    localparam int LEN_W    = 11;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int PTR_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int FIDX_W = $clog2(BANK_DEPTH + 1);
    localparam int WIDX_W = $clog2(BANK_DEPTH);
    localparam int CMP_W  = (FIDX_W > LEN_W) ? FIDX_W : LEN_W;

    localparam logic [KIND_W-1:0] KIND_PAIR       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAIN_GO   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAIN_DONE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;

    localparam logic [SAMPLE_W-1:0] CENTER_RST = 12'd2048;
    localparam logic [SAMPLE_W-1:0] MARGIN_RST = 12'd2000;
    localparam logic [LEN_W-1:0]    LENGTH_RST = 11'd1000;
    localparam logic [BYTE_W-1:0]   OUTLIER_BYTE = 8'd128;

    typedef struct packed {
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } omap_rd_t;

    typedef struct packed {
        logic                wr_en;
        logic [PTR_W-1:0]    wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
    } omap_wr_t;

endpackage

>>> hdl/outlier_moving_average_pingpong_top.sv
`timescale 1ns / 1ps
// top level: outlier test, bank fill control and result register
// depends on omap_pkg and omap_hist
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | s_valid / s_ready    | s_kind, s_sample_a, s_sample_b, s_send_enable
//  result   | m_valid / m_ready    | m_wrote .. m_ready_bank
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one transaction per cycle unless stalled; passes middle stage then result register
// bank control is updated at accept; history memory is read at accept and
// written when the middle stage advances, so consecutive pushes always touch different entries
// reset is synchronous, clears control state, history reads as zero until written
// a stalled result holds the middle stage and deasserts s_ready; cfg_ready is always high
module outlier_moving_average_pingpong_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [omap_pkg::KIND_W-1:0]       s_kind,
    input  logic [omap_pkg::SAMPLE_W-1:0]     s_sample_a,
    input  logic [omap_pkg::SAMPLE_W-1:0]     s_sample_b,
    input  logic                              s_send_enable,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_wrote,
    output logic                              m_write_bank,
    output logic [omap_pkg::WIDX_W-1:0]       m_write_index,
    output logic [omap_pkg::BYTE_W-1:0]       m_write_value,
    output logic                              m_was_outlier,
    output logic                              m_ready_pending,
    output logic                              m_ready_bank,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [omap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [omap_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import omap_pkg::*;

    logic [SAMPLE_W-1:0] center_reg;
    logic [SAMPLE_W-1:0] margin_reg;
    logic [LEN_W-1:0]    length_reg;

    logic [FIDX_W-1:0]   fill_index_reg, fill_index_next;
    logic                fill_bank_reg, fill_bank_next;
    logic                ready_flag_reg, ready_flag_next;
    logic                drain_busy_reg, drain_busy_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;

    logic                p1_valid_reg;
    logic                p1_wrote_reg;
    logic                p1_bank_reg;
    logic [WIDX_W-1:0]   p1_index_reg;
    logic                p1_outlier_reg;
    logic                p1_push_reg;
    logic [PTR_W-1:0]    p1_addr_reg;
    logic [SAMPLE_W-1:0] p1_avg_reg;
    logic                p1_pending_reg;
    logic                p1_rbank_reg;

    logic                m_valid_reg;
    logic                m_wrote_reg;
    logic                m_bank_reg;
    logic [WIDX_W-1:0]   m_index_reg;
    logic [BYTE_W-1:0]   m_value_reg;
    logic                m_outlier_reg;
    logic                m_pending_reg;
    logic                m_rbank_reg;

    logic                accept;
    logic                p1_advance;
    logic [FIDX_W-1:0]   len_eff;
    logic [SAMPLE_W:0]   pair_sum;
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] diff;
    logic                outlier;
    logic                writing;
    logic                push;
    logic [FIDX_W-1:0]   idx_after;
    logic [BYTE_W-1:0]   hist_byte;
    logic [BYTE_W-1:0]   value_sel;
    omap_rd_t            hist_rd;
    omap_wr_t            hist_wr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= CENTER_RST;
            margin_reg <= MARGIN_RST;
            length_reg <= LENGTH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CENTER: center_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_MARGIN: margin_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (length_reg == '0) begin
            len_eff = FIDX_W'(1);
        end else if (CMP_W'(length_reg) > CMP_W'(BANK_DEPTH)) begin
            len_eff = FIDX_W'(BANK_DEPTH);
        end else begin
            len_eff = FIDX_W'(length_reg);
        end
    end

    assign p1_advance = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !p1_valid_reg || p1_advance;
    assign accept     = s_valid && s_ready;

    assign pair_sum = {1'b0, s_sample_a} + {1'b0, s_sample_b};
    assign avg      = pair_sum[SAMPLE_W:1];
    assign diff     = (avg >= center_reg) ? (avg - center_reg) : (center_reg - avg);
    assign outlier  = diff > margin_reg;
    assign writing  = (s_kind == KIND_PAIR) && (fill_index_reg < len_eff);
    assign push     = writing && !outlier;
    assign idx_after = writing ? (fill_index_reg + FIDX_W'(1)) : fill_index_reg;

    always_comb begin
        fill_index_next = fill_index_reg;
        fill_bank_next  = fill_bank_reg;
        ready_flag_next = ready_flag_reg;
        drain_busy_next = drain_busy_reg;
        ptr_next        = ptr_reg;
        case (s_kind)
            KIND_PAIR: begin
                fill_index_next = idx_after;
                if (push) begin
                    ptr_next = (ptr_reg == PTR_W'(WINDOW_LEN - 1)) ? '0
                                                                  : ptr_reg + PTR_W'(1);
                end
                if (idx_after >= len_eff && s_send_enable && !drain_busy_reg) begin
                    ready_flag_next = 1'b1;
                    fill_bank_next  = ~fill_bank_reg;
                    fill_index_next = '0;
                end
            end
            KIND_DRAIN_GO: begin
                if (ready_flag_reg) begin
                    drain_busy_next = 1'b1;
                    ready_flag_next = 1'b0;
                end
            end
            KIND_DRAIN_DONE: begin
                drain_busy_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_index_reg <= '0;
            fill_bank_reg  <= 1'b0;
            ready_flag_reg <= 1'b0;
            drain_busy_reg <= 1'b0;
            ptr_reg        <= '0;
        end else if (accept) begin
            fill_index_reg <= fill_index_next;
            fill_bank_reg  <= fill_bank_next;
            ready_flag_reg <= ready_flag_next;
            drain_busy_reg <= drain_busy_next;
            ptr_reg        <= ptr_next;
        end
    end

    // middle stage waits for the history read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_wrote_reg   <= writing;
            p1_bank_reg    <= writing ? fill_bank_reg : 1'b0;
            p1_index_reg   <= writing ? fill_index_reg[WIDX_W-1:0] : '0;
            p1_outlier_reg <= writing && outlier;
            p1_push_reg    <= push;
            p1_addr_reg    <= ptr_reg;
            p1_avg_reg     <= avg;
            p1_pending_reg <= ready_flag_next;
            p1_rbank_reg   <= ~fill_bank_next;
        end
    end

    assign hist_rd.rd_en   = accept && push;
    assign hist_rd.rd_addr = ptr_reg;
    assign hist_wr.wr_en   = p1_advance && p1_push_reg;
    assign hist_wr.wr_addr = p1_addr_reg;
    assign hist_wr.wr_data = p1_avg_reg;

    omap_hist u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd       (hist_rd),
        .wr       (hist_wr),
        .avg_byte (hist_byte)
    );

    always_comb begin
        if (p1_push_reg) begin
            value_sel = hist_byte;
        end else if (p1_outlier_reg) begin
            value_sel = OUTLIER_BYTE;
        end else begin
            value_sel = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance) begin
            m_wrote_reg   <= p1_wrote_reg;
            m_bank_reg    <= p1_bank_reg;
            m_index_reg   <= p1_index_reg;
            m_value_reg   <= value_sel;
            m_outlier_reg <= p1_outlier_reg;
            m_pending_reg <= p1_pending_reg;
            m_rbank_reg   <= p1_rbank_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_wrote         = m_wrote_reg;
    assign m_write_bank    = m_bank_reg;
    assign m_write_index   = m_index_reg;
    assign m_write_value   = m_value_reg;
    assign m_was_outlier   = m_outlier_reg;
    assign m_ready_pending = m_pending_reg;
    assign m_ready_bank    = m_rbank_reg;

endmodule

>>> hdl/omap_hist.sv
`timescale 1ns / 1ps
// history ring memory with running window sum, divide by window length and scale down to a byte
// depends on omap_pkg
module omap_hist (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  omap_pkg::omap_rd_t      rd,
    input  omap_pkg::omap_wr_t      wr,
    output logic [omap_pkg::BYTE_W-1:0] avg_byte
);
    import omap_pkg::*;

    localparam int SHIFT   = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W = SUM_W + 2;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int PROD_W = SUM_W + RECIP_W;

    logic [SAMPLE_W-1:0]   mem [WINDOW_LEN];
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic                  rd_vld_reg;
    logic [WINDOW_LEN-1:0] vld_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [SAMPLE_W-1:0]   oldest;
    logic [PROD_W-1:0]     prod;

    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            mem[wr.wr_addr] <= wr.wr_data;
        end
        if (rd.rd_en) begin
            rd_data_reg <= mem[rd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            sum_reg    <= '0;
        end else begin
            if (rd.rd_en) begin
                rd_vld_reg <= vld_reg[rd.rd_addr];
            end
            if (wr.wr_en) begin
                vld_reg[wr.wr_addr] <= 1'b1;
                sum_reg <= sum_next;
            end
        end
    end

    // entries never written read as zero
    assign oldest   = rd_vld_reg ? rd_data_reg : '0;
    assign sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(wr.wr_data);
    assign prod     = PROD_W'(sum_next) * PROD_W'(RECIP);
    assign avg_byte = prod[SHIFT+4 +: BYTE_W];

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// testbench for outlier_moving_average_pingpong_top: directed and random transactions,
// a scoreboard class predicts every result; depends on omap_pkg and the block's rtl
module tb;
    import omap_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD = 300;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic              wrote;
        logic              bank;
        logic [WIDX_W-1:0] index;
        logic [BYTE_W-1:0] value;
        logic              outlier;
        logic              pending;
        logic              rbank;
    } bank_write_t;

    class fill_scoreboard;
        logic [SAMPLE_W-1:0] center;
        logic [SAMPLE_W-1:0] margin;
        logic [LEN_W-1:0]    length;
        logic [SAMPLE_W-1:0] window [WINDOW_LEN];
        int unsigned         fill_idx;
        logic                fill_bank;
        logic                ready_flag;
        logic                drain_busy;
        bank_write_t         expected_q [$];
        int                  errors;
        int                  n_inputs;
        int                  n_results;
        int                  n_swaps;
        int                  n_outliers;
        int                  n_dropped;

        function new();
            center = CENTER_RST;
            margin = MARGIN_RST;
            length = LENGTH_RST;
            foreach (window[i]) window[i] = '0;
            fill_idx = 0;
            fill_bank = 1'b0;
            ready_flag = 1'b0;
            drain_busy = 1'b0;
            errors = 0;
            n_inputs = 0;
            n_results = 0;
            n_swaps = 0;
            n_outliers = 0;
            n_dropped = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CENTER: center = data;
                CFG_MARGIN: margin = data;
                CFG_LENGTH: length = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic [KIND_W-1:0] kind, logic [SAMPLE_W-1:0] a,
                                 logic [SAMPLE_W-1:0] b, logic send);
            bank_write_t r;
            int unsigned len;
            int unsigned avg;
            int unsigned gap;
            int unsigned acc;
            r = '0;
            len = 32'(length);
            if (len < 1) len = 1;
            if (len > BANK_DEPTH) len = BANK_DEPTH;
            case (kind)
                KIND_PAIR: begin
                    if (fill_idx < len) begin
                        avg = (int'(a) + int'(b)) >> 1;
                        gap = (avg > center) ? avg - center : center - avg;
                        r.wrote = 1'b1;
                        r.bank = fill_bank;
                        r.index = fill_idx[WIDX_W-1:0];
                        if (gap > margin) begin
                            r.outlier = 1'b1;
                            r.value = OUTLIER_BYTE;
                            n_outliers++;
                        end else begin
                            acc = avg;
                            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                                window[i] = window[i + 1];
                                acc += window[i];
                            end
                            window[WINDOW_LEN - 1] = avg[SAMPLE_W-1:0];
                            r.value = BYTE_W'((acc / WINDOW_LEN) >> 4);
                        end
                        fill_idx++;
                    end else begin
                        n_dropped++;
                    end
                    // swap test also runs after a dropped pair
                    if (fill_idx >= len && send && !drain_busy) begin
                        ready_flag = 1'b1;
                        fill_bank = ~fill_bank;
                        fill_idx = 0;
                        n_swaps++;
                    end
                end
                KIND_DRAIN_GO: begin
                    if (ready_flag) begin
                        drain_busy = 1'b1;
                        ready_flag = 1'b0;
                    end
                end
                KIND_DRAIN_DONE: drain_busy = 1'b0;
                default: ;
            endcase
            r.pending = ready_flag;
            r.rbank = ~fill_bank;
            expected_q.push_back(r);
            n_inputs++;
        endfunction

        function void cmp(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(bank_write_t got);
            bank_write_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no transaction pending, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            cmp("wrote", want.wrote, got.wrote);
            cmp("write_bank", want.bank, got.bank);
            cmp("write_index", want.index, got.index);
            cmp("write_value", want.value, got.value);
            cmp("was_outlier", want.outlier, got.outlier);
            cmp("ready_pending", want.pending, got.pending);
            cmp("ready_bank", want.rbank, got.rbank);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [KIND_W-1:0]     s_kind = KIND_PAIR;
    logic [SAMPLE_W-1:0]   s_sample_a = '0;
    logic [SAMPLE_W-1:0]   s_sample_b = '0;
    logic                  s_send_enable = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_wrote;
    logic                  m_write_bank;
    logic [WIDX_W-1:0]     m_write_index;
    logic [BYTE_W-1:0]     m_write_value;
    logic                  m_was_outlier;
    logic                  m_ready_pending;
    logic                  m_ready_bank;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CENTER;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fill_scoreboard sb;
    idle_mode_t     idle_mode = IDLE_NONE;
    int             cur_center = 2048;
    int             cur_margin = 2000;
    int             n_settings = 1;
    int             hold_req = 0;
    int             hold_ack = 0;
    int             hold_left = 0;
    int             quiet_cycles = 0;

    outlier_moving_average_pingpong_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_sample_a      (s_sample_a),
        .s_sample_b      (s_sample_b),
        .s_send_enable   (s_send_enable),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_wrote         (m_wrote),
        .m_write_bank    (m_write_bank),
        .m_write_index   (m_write_index),
        .m_write_value   (m_write_value),
        .m_was_outlier   (m_was_outlier),
        .m_ready_pending (m_ready_pending),
        .m_ready_bank    (m_ready_bank),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    // result side: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if ((idle_mode == IDLE_RECV && $urandom_range(99) < 68) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(99) < 7)) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_kind, s_sample_a, s_sample_b, s_send_enable);
            if (m_valid && m_ready)
                sb.check_result('{m_wrote, m_write_bank, m_write_index, m_write_value,
                                  m_was_outlier, m_ready_pending, m_ready_bank});
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(logic [KIND_W-1:0] kind, logic [SAMPLE_W-1:0] a,
                             logic [SAMPLE_W-1:0] b, logic send);
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < 68) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 7)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_sample_a <= a;
        s_sample_b <= b;
        s_send_enable <= send;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] center, logic [CFG_DATA_W-1:0] margin,
                             logic [CFG_DATA_W-1:0] length);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] vals [3];
        idx = '{CFG_CENTER, CFG_MARGIN, CFG_LENGTH};
        vals = '{center, margin, length};
        wait_drained();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cur_center = int'(center);
        cur_margin = int'(margin);
        n_settings++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(3))
            0, 1: v = cur_center - cur_margin + int'($urandom_range(2 * cur_margin));
            2: v = $urandom_range(4095);
            default: v = $urandom_range(1) ? 4095 : 0;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic run_phase(logic [CFG_DATA_W-1:0] center, logic [CFG_DATA_W-1:0] margin,
                             logic [CFG_DATA_W-1:0] length, idle_mode_t mode, int items,
                             bit pressure);
        int n;
        int r;
        logic [KIND_W-1:0] kind;
        configure(center, margin, length);
        idle_mode = mode;
        if (pressure) hold_req++;
        n = 0;
        while (n < items) begin
            r = $urandom_range(99);
            if (r < 78) kind = KIND_PAIR;
            else if (r < 88) kind = KIND_DRAIN_GO;
            else if (r < 97) kind = KIND_DRAIN_DONE;
            else kind = KIND_UNUSED;
            send_item(kind, pick_sample(), pick_sample(), $urandom_range(3) != 0);
            if (kind != KIND_UNUSED) n++;
        end
        idle_mode = IDLE_NONE;
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // outlier boundaries at the reset settings
        send_item(KIND_PAIR, 0, 0, 1);
        send_item(KIND_PAIR, 4095, 4095, 1);
        send_item(KIND_PAIR, 48, 48, 1);
        send_item(KIND_PAIR, 4048, 4048, 1);
        send_item(KIND_PAIR, 4049, 4049, 1);
        send_item(KIND_PAIR, 47, 49, 1);
        send_item(KIND_PAIR, 4095, 0, 1);
        send_item(KIND_PAIR, 4095, 4094, 1);
        send_item(KIND_DRAIN_GO, 0, 0, 0);
        send_item(KIND_DRAIN_DONE, 0, 0, 0);
        send_item(KIND_UNUSED, 4095, 4095, 1);

        // zero fill length acts as one: swaps, drops and drain ordering
        configure(2048, 2000, 0);
        send_item(KIND_PAIR, 2048, 2048, 0);
        send_item(KIND_PAIR, 100, 200, 0);
        send_item(KIND_PAIR, 2000, 2100, 1);
        send_item(KIND_PAIR, 4095, 4095, 1);
        send_item(KIND_DRAIN_GO, 0, 0, 0);
        send_item(KIND_PAIR, 3000, 3000, 1);
        send_item(KIND_PAIR, 1, 1, 1);
        send_item(KIND_DRAIN_DONE, 0, 0, 0);
        send_item(KIND_DRAIN_DONE, 0, 0, 0);
        send_item(KIND_PAIR, 2500, 2600, 1);
        send_item(KIND_DRAIN_GO, 0, 0, 0);
        send_item(KIND_DRAIN_GO, 0, 0, 0);

        run_phase(2048, 400, 5, IDLE_NONE, 200, 1'b0);
        run_phase(0, 0, 1, IDLE_SEND, 200, 1'b0);
        run_phase(4095, 4095, 3, IDLE_RECV, 200, 1'b1);
        run_phase(CFG_DATA_W'($urandom_range(4095)), CFG_DATA_W'($urandom_range(4095)), 16,
                  IDLE_BOTH, 200, 1'b0);
        run_phase(1000, 1500, 1024, IDLE_NONE, 400, 1'b0);
        run_phase(CFG_DATA_W'($urandom_range(4095)), CFG_DATA_W'($urandom_range(4095)), 7,
                  IDLE_SEND, 200, 1'b0);
        run_phase(3000, 800, 2, IDLE_RECV, 200, 1'b1);
        run_phase(4095, 0, 2047, IDLE_BOTH, 60, 1'b0);

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("covered %0d input transactions over %0d register settings, %0d results checked",
                 sb.n_inputs, n_settings, sb.n_results);
        $display("%0d bank swaps, %0d outliers, %0d dropped pairs, %0d mismatches",
                 sb.n_swaps, sb.n_outliers, sb.n_dropped, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> outlier_moving_average_pingpong_top.f
hdl/omap_pkg.sv
hdl/omap_hist.sv
hdl/outlier_moving_average_pingpong_top.sv
sim/tb.sv
